FILE: sv/gcb_pkg.sv
// ----------------------------------------------------------------------------
// gcb_pkg: shared types and helpers for the glyph coverage blend
// Field widths, configuration register codes, the stage-to-stage
// transaction struct and the floor divide by 255.
// ----------------------------------------------------------------------------
package gcb_pkg;

    // field widths
    localparam int COV_W       = 8;
    localparam int OFF_W       = 3;
    localparam int COORD_W     = 11;
    localparam int PIX_W       = 16;
    localparam int PIX_IDX_W   = 19;
    localparam int ALPHA_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 40;

    // default panel size
    localparam int DEF_VIEW_WIDTH  = 800;
    localparam int DEF_VIEW_HEIGHT = 480;

    // register reset values
    localparam logic [PIX_W-1:0]   RST_TEXT_COLOR   = 16'h0000;
    localparam logic [ALPHA_W-1:0] RST_GLOBAL_ALPHA = 8'd220;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_ALPHA   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COVERAGE_DEPTH = 2'd2;

    localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'd255;

    // coverage depth codes
    typedef enum logic [1:0] {
        DEPTH_1BPP = 2'd0,
        DEPTH_2BPP = 2'd1,
        DEPTH_4BPP = 2'd2,
        DEPTH_8BPP = 2'd3
    } t_depth;

    // front end to blend stage transaction
    typedef struct packed {
        logic [PIX_IDX_W-1:0] idx;
        logic [ALPHA_W-1:0]   eff;
        logic [PIX_W-1:0]     bg;
    } t_mid;

    // floor(x / 255), exact for x up to 65279 (quotient fits in 8 bits)
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

FILE: sv/gcb_front.sv
// ----------------------------------------------------------------------------
// gcb_front: coverage decode, alpha scaling and index rotation
// Three register stages: decode and clip, multiply, divide and index sum.
// Pixels with zero effective alpha or off the panel drop out here.
// ----------------------------------------------------------------------------
module gcb_front #(
    parameter int VIEW_WIDTH  = gcb_pkg::DEF_VIEW_WIDTH,
    parameter int VIEW_HEIGHT = gcb_pkg::DEF_VIEW_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_vld,
    input  logic [gcb_pkg::COV_W-1:0]     i_cov_byte,
    input  logic [gcb_pkg::OFF_W-1:0]     i_bit_offset,
    input  logic [gcb_pkg::COORD_W-1:0]   i_user_x,
    input  logic [gcb_pkg::COORD_W-1:0]   i_user_y,
    input  logic [gcb_pkg::PIX_W-1:0]     i_bg,
    input  logic [gcb_pkg::ALPHA_W-1:0]   i_alpha,
    input  gcb_pkg::t_depth               i_depth,
    output logic                          o_vld,
    output gcb_pkg::t_mid                 o_mid
);
    import gcb_pkg::*;

    localparam logic [PIX_IDX_W-1:0] H_IDX  = PIX_IDX_W'(VIEW_HEIGHT);
    localparam logic [PIX_IDX_W-1:0] H_LAST = PIX_IDX_W'(VIEW_HEIGHT - 1);

    logic [COV_W-1:0] w_cov;
    logic [1:0]       w_pair;
    logic [3:0]       w_nib;
    logic             w_onscreen;

    // stage 1 registers
    logic                 r1_vld;
    logic [COV_W-1:0]     r1_cov;
    logic [COORD_W-2:0]   r1_x;
    logic [COORD_W-2:0]   r1_y;
    logic [PIX_W-1:0]     r1_bg;
    // stage 2 registers
    logic                 r2_vld;
    logic [15:0]          r2_prod;
    logic [PIX_IDX_W-1:0] r2_xprod;
    logic [COORD_W-2:0]   r2_y;
    logic [PIX_W-1:0]     r2_bg;
    // stage 3 registers
    logic                 r3_vld;
    t_mid                 r3_mid;
    logic [ALPHA_W-1:0]   n3_eff;

    // coverage decode, code replicated into 8 bits equals code times 255/max
    always_comb begin
        w_pair = i_cov_byte[{2'd3 - i_bit_offset[2:1], 1'b0} +: 2];
        w_nib  = i_bit_offset[2] ? i_cov_byte[3:0] : i_cov_byte[7:4];
        unique case (i_depth)
            DEPTH_1BPP: w_cov = {8{i_cov_byte[3'd7 - i_bit_offset]}};
            DEPTH_2BPP: w_cov = {4{w_pair}};
            DEPTH_4BPP: w_cov = {2{w_nib}};
            DEPTH_8BPP: w_cov = i_cov_byte;
            default:    w_cov = i_cov_byte;
        endcase
    end

    // panel clip
    assign w_onscreen = !i_user_x[COORD_W-1] && !i_user_y[COORD_W-1]
                     && (32'(i_user_x[COORD_W-2:0]) < 32'(VIEW_WIDTH))
                     && (32'(i_user_y[COORD_W-2:0]) < 32'(VIEW_HEIGHT));

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_adv) begin
            r1_vld <= i_vld && w_onscreen && (w_cov != '0);
            r2_vld <= r1_vld;
            r3_vld <= r2_vld && (n3_eff != '0);
        end
    end

    assign n3_eff = div255(r2_prod);

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_cov         <= w_cov;
            r1_x           <= i_user_x[COORD_W-2:0];
            r1_y           <= i_user_y[COORD_W-2:0];
            r1_bg          <= i_bg;
            r2_prod        <= 16'(r1_cov) * 16'(i_alpha);
            r2_xprod       <= PIX_IDX_W'(r1_x) * H_IDX;
            r2_y           <= r1_y;
            r2_bg          <= r1_bg;
            r3_mid.eff     <= n3_eff;
            r3_mid.idx     <= r2_xprod + H_LAST - PIX_IDX_W'(r2_y);
            r3_mid.bg      <= r2_bg;
        end
    end

    assign o_vld = r3_vld;
    assign o_mid = r3_mid;

endmodule

FILE: sv/gcb_blend.sv
// ----------------------------------------------------------------------------
// gcb_blend: per-channel RGB565 mix of text color over background
// Stage 4 forms the weighted sums, stage 5 divides by 255 and is the
// output register.
// ----------------------------------------------------------------------------
module gcb_blend (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic                           i_vld,
    input  gcb_pkg::t_mid                  i_mid,
    input  logic [gcb_pkg::PIX_W-1:0]      i_text_color,
    output logic                           o_vld,
    output logic [gcb_pkg::PIX_IDX_W-1:0]  o_idx,
    output logic [gcb_pkg::PIX_W-1:0]      o_val
);
    import gcb_pkg::*;

    logic [ALPHA_W-1:0]   w_inv;

    // stage 4 registers
    logic                 r4_vld;
    logic                 r4_full;
    logic [PIX_IDX_W-1:0] r4_idx;
    logic [12:0]          r4_sum_r;
    logic [13:0]          r4_sum_g;
    logic [12:0]          r4_sum_b;
    // stage 5 registers
    logic                 r5_vld;
    logic [PIX_IDX_W-1:0] r5_idx;
    logic [PIX_W-1:0]     r5_val;
    logic [PIX_W-1:0]     n5_val;

    assign w_inv = ALPHA_FULL - i_mid.eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_adv) begin
            r4_vld <= i_vld;
            r5_vld <= r4_vld;
        end
    end

    // divide by 255 and pack, full alpha takes the text color as is
    always_comb begin
        if (r4_full) begin
            n5_val = i_text_color;
        end else begin
            n5_val = {5'(div255(16'(r4_sum_r))), 6'(div255(16'(r4_sum_g))),
                      5'(div255(16'(r4_sum_b)))};
        end
    end

    // weighted sums, then result
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_full  <= (i_mid.eff == ALPHA_FULL);
            r4_idx   <= i_mid.idx;
            r4_sum_r <= 13'(i_text_color[15:11]) * 13'(i_mid.eff)
                      + 13'(i_mid.bg[15:11]) * 13'(w_inv);
            r4_sum_g <= 14'(i_text_color[10:5]) * 14'(i_mid.eff)
                      + 14'(i_mid.bg[10:5]) * 14'(w_inv);
            r4_sum_b <= 13'(i_text_color[4:0]) * 13'(i_mid.eff)
                      + 13'(i_mid.bg[4:0]) * 13'(w_inv);
            r5_idx   <= r4_idx;
            r5_val   <= n5_val;
        end
    end

    assign o_vld = r5_vld;
    assign o_idx = r5_idx;
    assign o_val = r5_val;

endmodule

FILE: sv/glyph_coverage_rgb565_blend.sv
// ----------------------------------------------------------------------------
// glyph_coverage_rgb565_blend: anti-aliased glyph pixel blend
// Decodes glyph coverage, scales it by global alpha, rotates the point
// into a portrait framebuffer index and mixes text color over background.
// ----------------------------------------------------------------------------
// Takes one glyph pixel per clock unless stalled; its register stages are
// decode and clip, the coverage-times-alpha multiply, its divide by 255 with
// the index sum, and the two-step channel mix (multiply, then divide by 255).
// Pixels that are off the panel or have zero effective alpha give no result
// and leave a bubble. The whole pipeline stalls only while a result sits in
// the output register and the sink is not ready. Configuration writes are
// always taken and must only happen while no pixel is in flight.
module glyph_coverage_rgb565_blend #(
    parameter int VIEW_WIDTH  = gcb_pkg::DEF_VIEW_WIDTH,
    parameter int VIEW_HEIGHT = gcb_pkg::DEF_VIEW_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // pixel input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // coverage_byte, bit_offset, user_x, user_y, background_pixel, zero pad
    input  logic [gcb_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // framebuffer write output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pixel_index, pixel_value, zero pad
    output logic [gcb_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // configuration write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gcb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gcb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import gcb_pkg::*;

    logic [PIX_W-1:0]     r_text_color;
    logic [ALPHA_W-1:0]   r_global_alpha;
    t_depth               r_coverage_depth;

    logic                 w_adv;
    logic                 w_mid_vld;
    t_mid                 w_mid;
    logic                 w_out_vld;
    logic [PIX_IDX_W-1:0] w_out_idx;
    logic [PIX_W-1:0]     w_out_val;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color     <= RST_TEXT_COLOR;
            r_global_alpha   <= RST_GLOBAL_ALPHA;
            r_coverage_depth <= DEPTH_4BPP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TEXT_COLOR:     r_text_color     <= i_cfg_data;
                CFG_GLOBAL_ALPHA:   r_global_alpha   <= i_cfg_data[ALPHA_W-1:0];
                CFG_COVERAGE_DEPTH: r_coverage_depth <= t_depth'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // pipeline moves unless a result waits on a stalled sink
    assign w_adv         = !w_out_vld || m_axis_tready;
    assign s_axis_tready = w_adv;

    gcb_front #(
        .VIEW_WIDTH  (VIEW_WIDTH),
        .VIEW_HEIGHT (VIEW_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_vld        (s_axis_tvalid),
        .i_cov_byte   (s_axis_tdata[7:0]),
        .i_bit_offset (s_axis_tdata[10:8]),
        .i_user_x     (s_axis_tdata[21:11]),
        .i_user_y     (s_axis_tdata[32:22]),
        .i_bg         (s_axis_tdata[48:33]),
        .i_alpha      (r_global_alpha),
        .i_depth      (r_coverage_depth),
        .o_vld        (w_mid_vld),
        .o_mid        (w_mid)
    );

    gcb_blend u_blend (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_vld        (w_mid_vld),
        .i_mid        (w_mid),
        .i_text_color (r_text_color),
        .o_vld        (w_out_vld),
        .o_idx        (w_out_idx),
        .o_val        (w_out_val)
    );

    assign m_axis_tvalid = w_out_vld;
    assign m_axis_tdata  = {5'd0, w_out_val, w_out_idx};

    // checks

    // a pixel reaching the mixer always has nonzero effective alpha
    a_mid_eff_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_vld |-> (w_mid.eff != '0))
        else $error("blend stage received zero effective alpha");

    // index stays inside the panel when the panel fits the index width
    a_idx_in_panel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (VIEW_WIDTH * VIEW_HEIGHT <= (1 << PIX_IDX_W)))
        |-> (32'(w_out_idx) < 32'(VIEW_WIDTH * VIEW_HEIGHT)))
        else $error("pixel index outside panel");

    // a stalled sink freezes the input side in the same cycle
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while output stalled");

endmodule
